FILE: design/cpm_pkg.sv
// Shared constants and register indexes for the capture period meter.
`default_nettype none
package cpm_pkg;
	localparam int FUNC_W = 2;
	localparam int CAP_W = 16;
	localparam int PERIOD_W = 15;
	localparam int HIT_W = 32;
	localparam int FREQ_W = 26;
	localparam int TICK_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam int DVD_W = 28;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 2'd2;

	localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd2000000;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
endpackage
`default_nettype wire

FILE: design/cpm_if.sv
// Event and result channel interfaces of the capture period meter.
`default_nettype none
interface cpm_evt_if;
	import cpm_pkg::*;
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic [CAP_W-1:0] capture_value;
	modport source(output valid, output func, output capture_value, input ready);
	modport sink(input valid, input func, input capture_value, output ready);
endinterface

interface cpm_res_if;
	import cpm_pkg::*;
	logic valid;
	logic ready;
	logic accepted;
	logic [PERIOD_W-1:0] period_ticks;
	logic ready_res;
	logic [HIT_W-1:0] hit_count;
	logic [FREQ_W-1:0] freq_hz_x10;
	modport source(output valid, output accepted, output period_ticks, output ready_res,
		output hit_count, output freq_hz_x10, input ready);
	modport sink(input valid, input accepted, input period_ticks, input ready_res,
		input hit_count, input freq_hz_x10, output ready);
endinterface
`default_nettype wire

FILE: design/capture_period_meter_top.sv
// Capture period meter: stamp and period update, bit-serial frequency divider.
//
// Channel   Dir   Beat contents
// evt       in    func, capture_value
// res       out   accepted, period_ticks, ready_res, hit_count, freq_hz_x10
// cfg       in    cfg_wr_en, cfg_index, cfg_data (no handshake)
//
// Each event passes through these steps from acceptance to a result beat: the measurement
// state is updated, the divider is loaded, the restoring divider runs one quotient bit per
// cycle, and the result is handed to the output register.
// The next event is taken once the result has moved into the output register, even if
// it still waits there; a result still waiting holds the divider done and stalls input.
// Reset is asynchronous and active low and leaves the block idle with no result held.
`default_nettype none
module capture_period_meter_top #(
	parameter int COUNTER_MAX = 65535
) (
	input wire logic clk,
	input wire logic arst_n,
	cpm_evt_if.sink evt,
	cpm_res_if.source res,
	input wire logic cfg_wr_en,
	input wire logic [cpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cpm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cpm_pkg::*;

	localparam logic [CAP_W-1:0] CMAX = CAP_W'(COUNTER_MAX);
	localparam logic [CAP_W:0] HALF_MAX = (CAP_W+1)'(COUNTER_MAX / 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [CNT_W-1:0] count_q;

	logic enable_q;
	logic channel_q;
	logic [TICK_W-1:0] tick_q;

	logic have_prev_q;
	logic [CAP_W-1:0] prev_stamp_q;
	logic [PERIOD_W-1:0] period_q;
	logic ready_flag_q;
	logic [HIT_W-1:0] hit_q;
	logic acc_q;

	logic [DVD_W-1:0] dvd_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [CAP_W-1:0] rem_q;
	logic zero_q;

	logic out_valid_q;
	logic out_acc_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic out_ready_q;
	logic [HIT_W-1:0] out_hit_q;
	logic [FREQ_W-1:0] out_freq_q;

	logic evt_fire;
	logic acc;
	logic [CAP_W-1:0] stamp;
	logic [CAP_W:0] period;
	logic period_ok;
	logic [CAP_W-1:0] rem_shift;
	logic rem_ge;
	logic [CAP_W-1:0] rem_next;
	logic out_free;
	logic [FREQ_W-1:0] freq;
	logic en_rise;

	assign evt.ready = (state_q == ST_IDLE);
	assign evt_fire = evt.valid && evt.ready;
	assign acc = enable_q && (evt.func == {1'b0, channel_q});
	assign en_rise = cfg_wr_en && (cfg_index == REG_ENABLE) && cfg_data[0] && !enable_q;

	always_comb begin
		stamp = (evt.capture_value <= CMAX) ? (CMAX - evt.capture_value) : '0;
		if (stamp >= prev_stamp_q) begin
			period = {1'b0, stamp} - {1'b0, prev_stamp_q};
		end else begin
			period = {1'b0, stamp} + {1'b0, CMAX - prev_stamp_q} + 17'd1;
		end
		period_ok = (period > 17'd1) && (period < HALF_MAX);
	end

	always_comb begin
		rem_shift = {rem_q[CAP_W-2:0], dvd_q[DVD_W-1]};
		rem_ge = rem_shift >= {1'b0, dsr_q};
		rem_next = rem_ge ? (rem_shift - {1'b0, dsr_q}) : rem_shift;
		if (zero_q) begin
			freq = '0;
		end else if (dvd_q[DVD_W-1:FREQ_W] != '0) begin
			freq = FREQ_MAX;
		end else begin
			freq = dvd_q[FREQ_W-1:0];
		end
	end

	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			channel_q <= 1'b0;
			tick_q <= TICK_RATE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_CHANNEL: channel_q <= cfg_data[0];
				REG_TICK_RATE: tick_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_stamp_q <= '0;
			period_q <= '0;
			ready_flag_q <= 1'b0;
			hit_q <= '0;
			acc_q <= 1'b0;
		end else if (en_rise) begin
			have_prev_q <= 1'b0;
			prev_stamp_q <= '0;
			period_q <= '0;
			ready_flag_q <= 1'b0;
			hit_q <= '0;
		end else if (evt_fire) begin
			acc_q <= acc;
			if (acc) begin
				hit_q <= hit_q + 32'd1;
				if (have_prev_q && period_ok) begin
					period_q <= period[PERIOD_W-1:0];
					ready_flag_q <= 1'b1;
				end
				prev_stamp_q <= stamp;
				have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (evt_fire) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					count_q <= CNT_W'(DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					count_q <= count_q - CNT_W'(1);
					if (count_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			dvd_q <= {1'b0, tick_q, 3'b000} + {3'b000, tick_q, 1'b0};
			dsr_q <= period_q;
			rem_q <= '0;
			zero_q <= (period_q == '0) || (tick_q == '0);
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_acc_q <= acc_q;
			out_period_q <= period_q;
			out_ready_q <= ready_flag_q && enable_q;
			out_hit_q <= hit_q;
			out_freq_q <= freq;
		end
	end

	assign res.valid = out_valid_q;
	assign res.accepted = out_acc_q;
	assign res.period_ticks = out_period_q;
	assign res.ready_res = out_ready_q;
	assign res.hit_count = out_hit_q;
	assign res.freq_hz_x10 = out_freq_q;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		evt_fire |=> !evt.ready)
		else $error("event channel still ready after taking a beat");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !zero_q) |-> (rem_q < {1'b0, dsr_q}))
		else $error("divider remainder not below divisor");

	a_ready_has_period: assert property (@(posedge clk) disable iff (!arst_n)
		ready_flag_q |-> (period_q > 15'd1))
		else $error("ready flag set without a valid period");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside the done state");
endmodule
`default_nettype wire

FILE: dv/cpm_meter_checker.sv
// Checker that predicts and compares the result beats of the capture period meter.
`timescale 1ns / 100ps
module cpm_meter_checker
	import cpm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cpm_evt_if evt,
	cpm_res_if res,
	input logic cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output int fails,
	output int pending
);
	localparam int unsigned METER_SPAN = 65535;

	typedef struct packed {
		logic accepted;
		logic [PERIOD_W-1:0] period_ticks;
		logic ready_res;
		logic [HIT_W-1:0] hit_count;
		logic [FREQ_W-1:0] freq_hz_x10;
	} meter_result_t;

	meter_result_t expected_results[$];

	logic cap_enable;
	logic cap_channel;
	logic [TICK_W-1:0] tick_rate;
	logic seen_stamp;
	logic [CAP_W-1:0] last_stamp;
	logic [PERIOD_W-1:0] held_period;
	logic period_ok;
	logic [HIT_W-1:0] hits;
	int errors = 0;

	task automatic clear_measurement();
		seen_stamp = 1'b0;
		last_stamp = '0;
		held_period = '0;
		period_ok = 1'b0;
		hits = '0;
	endtask

	task automatic measure_event(input logic [FUNC_W-1:0] f, input logic [CAP_W-1:0] v,
		output meter_result_t r);
		int unsigned stamp;
		int unsigned span;
		longint unsigned q;
		r.accepted = cap_enable && (f == {1'b0, cap_channel});
		if (r.accepted) begin
			stamp = METER_SPAN - v;
			hits = hits + 1'b1;
			if (seen_stamp) begin
				span = (stamp >= last_stamp) ? stamp - last_stamp
					: stamp + (METER_SPAN - last_stamp) + 1;
				if (span > 1 && span < METER_SPAN / 2) begin
					held_period = span[PERIOD_W-1:0];
					period_ok = 1'b1;
				end
			end
			last_stamp = stamp[CAP_W-1:0];
			seen_stamp = 1'b1;
		end
		r.period_ticks = held_period;
		r.ready_res = period_ok & cap_enable;
		r.hit_count = hits;
		if (held_period == 0 || tick_rate == 0) begin
			r.freq_hz_x10 = '0;
		end else begin
			q = tick_rate;
			q = (q * 10) / held_period;
			r.freq_hz_x10 = (q > FREQ_MAX) ? FREQ_MAX : q[FREQ_W-1:0];
		end
	endtask

	function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		meter_result_t want;
		int bad;
		if (!arst_n) begin
			expected_results.delete();
			cap_enable = 1'b0;
			cap_channel = 1'b0;
			tick_rate = TICK_RATE_RESET;
			clear_measurement();
			pending <= 0;
			fails <= errors;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with no event waiting for it", $time);
					errors++;
				end else begin
					want = expected_results.pop_front();
					bad = field_diff("accepted", want.accepted, res.accepted)
						+ field_diff("period_ticks", want.period_ticks, res.period_ticks)
						+ field_diff("ready_res", want.ready_res, res.ready_res)
						+ field_diff("hit_count", want.hit_count, res.hit_count)
						+ field_diff("freq_hz_x10", want.freq_hz_x10, res.freq_hz_x10);
					if (bad != 0)
						errors++;
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ENABLE: begin
						if (cfg_data[0] && !cap_enable)
							clear_measurement();
						cap_enable = cfg_data[0];
					end
					REG_CHANNEL: begin
						cap_channel = cfg_data[0];
					end
					REG_TICK_RATE: begin
						tick_rate = cfg_data[TICK_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (evt.valid && evt.ready) begin
				measure_event(evt.func, evt.capture_value, want);
				expected_results.push_back(want);
			end
			pending <= expected_results.size();
			fails <= errors;
		end
	end
endmodule

FILE: dv/tb_top.sv
// Testbench top: clock, reset, event stimulus, configuration writes and the verdict.
`timescale 1ns / 100ps
module tb_top;
	import cpm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [FUNC_W-1:0] FUNC_CAP0 = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CAP1 = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_OTHER = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_OTHER_HI = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int pending_count;
	int snd_pct = 0;
	int rcv_pct = 0;
	int hold_orders = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;
	logic cur_en = 1'b0;
	logic cur_ch = 1'b0;
	logic [CAP_W-1:0] down_val = '1;

	cpm_evt_if evt_ch();
	cpm_res_if res_ch();

	capture_period_meter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cpm_meter_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fails(fail_count),
		.pending(pending_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL capture_period_meter_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_orders != hold_seen) begin
			hold_seen = hold_orders;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rcv_pct);
		end
	end

	task automatic send_event(input logic [FUNC_W-1:0] f, input logic [CAP_W-1:0] v);
		while ($urandom_range(99) < snd_pct) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.func <= f;
		evt_ch.capture_value <= v;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	task automatic drain();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic en, input logic ch, input logic [TICK_W-1:0] tick);
		logic [CFG_DATA_W-1:0] word;
		drain();
		reg_write(REG_UNUSED, CFG_DATA_W'($urandom));
		word = CFG_DATA_W'($urandom);
		word[0] = ch;
		reg_write(REG_CHANNEL, word);
		reg_write(REG_TICK_RATE, tick);
		word = CFG_DATA_W'($urandom);
		word[0] = en;
		reg_write(REG_ENABLE, word);
		cfg_wr_en <= 1'b0;
		cur_en = en;
		cur_ch = ch;
	endtask

	// Most events continue a down-counting capture sequence on the active channel.
	task automatic random_event();
		int unsigned pick;
		int unsigned k;
		int unsigned gap;
		logic [FUNC_W-1:0] f;
		logic [CAP_W-1:0] v;
		pick = $urandom_range(99);
		if (pick < 80) begin
			k = $urandom_range(99);
			if (k < 40)
				gap = $urandom_range(300, 2);
			else if (k < 85)
				gap = $urandom_range(32766, 2);
			else if (k < 90)
				gap = $urandom_range(1, 0);
			else
				gap = $urandom_range(65535, 32767);
			down_val = down_val - CAP_W'(gap);
			f = {1'b0, cur_ch};
			v = down_val;
		end else if (pick < 88) begin
			f = {1'b0, ~cur_ch};
			v = CAP_W'($urandom);
		end else if (pick < 96) begin
			f = ($urandom_range(1) != 0) ? FUNC_OTHER : FUNC_OTHER_HI;
			v = CAP_W'($urandom);
		end else begin
			f = {1'b0, cur_ch};
			v = CAP_W'($urandom);
			down_val = v;
		end
		send_event(f, v);
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		evt_ch.valid = 1'b0;
		evt_ch.func = '0;
		evt_ch.capture_value = '0;
		res_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(FUNC_CAP0, 16'h1234);
		configure(1'b1, 1'b0, TICK_RATE_RESET);
		send_event(FUNC_CAP0, 16'hFFFF);
		send_event(FUNC_CAP0, 16'd65435);
		send_event(FUNC_CAP1, 16'h0000);
		send_event(FUNC_OTHER, 16'hAAAA);
		send_event(FUNC_OTHER_HI, 16'h5555);
		send_event(FUNC_CAP0, 16'd65434);
		send_event(FUNC_CAP0, 16'd65434);
		send_event(FUNC_CAP0, 16'd65432);
		send_event(FUNC_CAP0, 16'd32666);
		send_event(FUNC_CAP0, 16'd65435);
		send_event(FUNC_CAP0, 16'h0000);
		send_event(FUNC_CAP0, 16'd65485);
		configure(1'b0, 1'b0, TICK_RATE_RESET);
		send_event(FUNC_CAP0, 16'h0100);
		send_event(FUNC_CAP0, 16'h0001);
		configure(1'b1, 1'b1, 24'hFFFFFF);
		send_event(FUNC_CAP1, 16'hFFFF);
		send_event(FUNC_CAP1, 16'hFFFD);
		send_event(FUNC_CAP0, 16'h7777);
		configure(1'b1, 1'b1, 24'd0);
		send_event(FUNC_CAP1, 16'hFFFA);
		configure(1'b1, 1'b1, 24'd1);
		send_event(FUNC_CAP1, 16'h8000);
		configure(1'b1, 1'b1, 24'd10000000);
		send_event(FUNC_CAP1, 16'h7FFE);

		for (ph = 0; ph < 9; ph++) begin
			case (ph % 4)
				0: begin
					snd_pct = 0;
					rcv_pct = 0;
				end
				1: begin
					snd_pct = 67;
					rcv_pct = 0;
				end
				2: begin
					snd_pct = 0;
					rcv_pct = 67;
				end
				default: begin
					snd_pct = 11;
					rcv_pct = 11;
				end
			endcase
			case (ph)
				0: configure(1'b1, 1'b0, TICK_RATE_RESET);
				1: configure(1'b1, 1'b1, 24'd10000000);
				2: configure(1'b0, 1'b1, 24'd1);
				3: configure(1'b1, 1'b0, 24'hFFFFFF);
				4: configure(1'b1, 1'b1, 24'd0);
				5: configure(1'b1, 1'b0, 24'd1);
				6: configure(1'b0, 1'b0, 24'd5000);
				7: configure(1'b1, 1'($urandom_range(1)), TICK_W'($urandom_range(10000000, 1)));
				default: configure(1'b1, 1'($urandom_range(1)), TICK_W'($urandom));
			endcase
			down_val = CAP_W'($urandom);
			repeat (cur_en ? 80 : 40) random_event();
		end

		snd_pct = 0;
		rcv_pct = 0;
		configure(1'b1, 1'($urandom_range(1)), TICK_W'($urandom_range(10000000, 1)));
		hold_orders <= hold_orders + 1;
		repeat (30) random_event();

		drain();
		if (fail_count == 0)
			$display("PASS capture_period_meter_top");
		else
			$display("FAIL capture_period_meter_top");
		$finish;
	end
endmodule
